>>> rtl/csm_pkg.sv
// Shared types and constants of the counting string matcher.
package csm_pkg;

   localparam int WINDOW_SLOTS_DEF  = 64;
   localparam int ALPHABET_SIZE_DEF = 256;
   localparam int COUNT_W           = 7;
   localparam int COUNT_MAX         = 127;
   localparam int SLOT_IDX_W        = 8;
   localparam int LEN_W             = 7;
   localparam int POS_W             = 32;
   localparam int BYTE_W            = 8;
   localparam int PIDX_W            = 6;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_PATTERN = 2'd1,
      CMD_TEXT    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                  shift;
      logic                  clear;
      logic                  vote_en;
      logic [SLOT_IDX_W-1:0] vote_slot;
      logic                  check_en;
      logic [SLOT_IDX_W-1:0] check_slot;
      logic [LEN_W-1:0]      length;
   } cell_ctl_type;

endpackage

>>> rtl/csm_table.sv
// Byte-to-pattern-index table: memory for indexes, flip-flop valid bits.
module csm_table #(
   parameter int ALPHABET_SIZE = csm_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic                       wr_en,
   input  logic                       clr,
   input  logic [csm_pkg::BYTE_W-1:0] addr,
   input  logic [csm_pkg::PIDX_W-1:0] wr_index,
   output logic                       hit,
   output logic [csm_pkg::PIDX_W-1:0] index
);

   localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

   logic [csm_pkg::PIDX_W-1:0] table_mem_ff [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0]   valid_ff;
   logic [ALPHABET_SIZE-1:0]   valid_in;
   logic                       hit_ff;
   logic                       hit_in;
   logic [csm_pkg::PIDX_W-1:0] index_ff;
   logic                       in_range;
   logic [AW-1:0]              slot;

   assign in_range = (32'(addr) < 32'(ALPHABET_SIZE));
   assign slot     = AW'(addr);

   always_comb begin
      valid_in = valid_ff;
      if (clr) begin
         valid_in = '0;
      end else if (wr_en && in_range) begin
         valid_in[slot] = 1'b1;
      end
   end

   assign hit_in = in_range && valid_ff[slot];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            hit_ff <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         table_mem_ff[slot] <= wr_index;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         index_ff <= table_mem_ff[slot];
      end
   end

   assign hit   = hit_ff;
   assign index = index_ff;

endmodule

>>> rtl/csm_cell.sv
// One vote counter of the rotating chain, indexed by distance to the current byte.
module csm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  csm_pkg::cell_ctl_type       ctl,
   input  logic [csm_pkg::COUNT_W-1:0] count_prev,
   output logic [csm_pkg::COUNT_W-1:0] count_out,
   output logic                        match
);

   localparam int IW = csm_pkg::SLOT_IDX_W;
   localparam int CW = csm_pkg::COUNT_W;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] voted;
   logic          vote_here;
   logic          check_here;

   assign vote_here  = ctl.vote_en && (ctl.vote_slot == IW'(CELL_INDEX));
   assign check_here = ctl.check_en && (ctl.check_slot == IW'(CELL_INDEX));

   always_comb begin
      voted = count_ff;
      if (vote_here && (count_ff < CW'(csm_pkg::COUNT_MAX))) begin
         voted = count_ff + CW'(1);
      end
   end

   assign match     = ctl.shift && check_here && (voted == ctl.length);
   assign count_out = check_here ? '0 : voted;

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.shift) begin
         count_in = count_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/counting_string_matcher_unit.sv
// Top level of the counting string matcher: input stage, table, cell chain, result register.
// Path: a text transaction waits in the input stage; its match is registered onto rsp_valid.
// Throughput: one transaction per clock; the table read stage and the counter chain both
// take a transaction every cycle, stalling only when the result register is held.
// Reset (synchronous): clears table valid bits, all counters, text position and pipeline;
// pattern length returns to 1. No clearing pass; the block is ready right after reset.
module counting_string_matcher_unit #(
   parameter int WINDOW_SLOTS  = csm_pkg::WINDOW_SLOTS_DEF,
   parameter int ALPHABET_SIZE = csm_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_command,
   input  logic [csm_pkg::BYTE_W-1:0] req_data_byte,
   input  logic [csm_pkg::PIDX_W-1:0] req_pattern_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [csm_pkg::POS_W-1:0]  rsp_match_position,
   input  logic                       csr_write_enable,
   input  logic [csm_pkg::LEN_W-1:0]  csr_write_data
);

   localparam int LW = csm_pkg::LEN_W;
   localparam int PW = csm_pkg::POS_W;
   localparam int IW = csm_pkg::SLOT_IDX_W;
   localparam int CW = csm_pkg::COUNT_W;

   logic                       req_accept;
   logic                       advance;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   csm_pkg::cmd_type           s1_cmd_ff;
   csm_pkg::cmd_type           req_cmd;
   logic                       tbl_hit;
   logic [csm_pkg::PIDX_W-1:0] tbl_index;
   logic [LW-1:0]              length_ff;
   logic [LW-1:0]              m_len;
   logic [PW-1:0]              text_pos_ff;
   logic [PW-1:0]              text_pos_in;
   logic [PW-1:0]              m_minus1;
   logic                       early;
   logic                       vote_ok;
   logic                       is_text;
   logic                       is_start;
   csm_pkg::cell_ctl_type      ctl;
   logic [CW-1:0]              cell_out [WINDOW_SLOTS];
   logic [WINDOW_SLOTS-1:0]    cell_match;
   logic                       match_any;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [PW-1:0]              rsp_pos_ff;

   assign req_cmd    = csm_pkg::cmd_type'(req_command);
   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff <= req_cmd;
      end
   end

   csm_table #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .wr_en   (req_accept && (req_cmd == csm_pkg::CMD_PATTERN)),
      .clr     (req_accept && (req_cmd == csm_pkg::CMD_START)),
      .addr    (req_data_byte),
      .wr_index(req_pattern_index),
      .hit     (tbl_hit),
      .index   (tbl_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LW'(1);
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
      end
   end

   always_comb begin
      m_len = length_ff;
      if (length_ff == '0) begin
         m_len = LW'(1);
      end else if (32'(length_ff) > WINDOW_SLOTS) begin
         m_len = LW'(WINDOW_SLOTS);
      end
   end

   assign m_minus1 = PW'(m_len) - PW'(1);
   assign early    = (text_pos_ff < m_minus1);
   assign is_text  = (s1_cmd_ff == csm_pkg::CMD_TEXT);
   assign is_start = (s1_cmd_ff == csm_pkg::CMD_START);
   assign vote_ok  = tbl_hit && (LW'(tbl_index) < m_len)
                     && (!early || (text_pos_ff >= PW'(tbl_index)));

   always_comb begin
      ctl.shift      = advance && is_text;
      ctl.clear      = advance && is_start;
      ctl.vote_en    = vote_ok;
      ctl.vote_slot  = IW'(tbl_index);
      ctl.check_en   = !early;
      ctl.check_slot = IW'(m_len - LW'(1));
      ctl.length     = m_len;
   end

   for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
      csm_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .count_prev(cell_out[(i + WINDOW_SLOTS - 1) % WINDOW_SLOTS]),
         .count_out (cell_out[i]),
         .match     (cell_match[i])
      );
   end

   assign match_any = |cell_match;

   always_comb begin
      text_pos_in = text_pos_ff;
      if (ctl.clear) begin
         text_pos_in = '0;
      end else if (ctl.shift) begin
         text_pos_in = text_pos_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_pos_ff <= '0;
      end else begin
         text_pos_ff <= text_pos_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (match_any) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (match_any) begin
         rsp_pos_ff <= text_pos_ff - m_minus1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_position = rsp_pos_ff;

endmodule

>>> rtl/csm_checker.sv
// Port-level checks of the counting string matcher, bound to the top level.
module csm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [csm_pkg::POS_W-1:0] rsp_match_position
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match_position))
      else $error("result changed while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_stall: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

   a_stall_no_rsp_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> !(rsp_valid && !rsp_stall))
      else $error("input stalled while result drains");

endmodule

bind counting_string_matcher_unit csm_checker u_csm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_match_position(rsp_match_position)
);
